// ===== rtl/midi_input_event_parser_unit_defines.svh =====
// assertion macros for the midi input event parser unit
// depends on nothing; used by the top level, which provides clk and rst_n
`ifndef MIDI_INPUT_EVENT_PARSER_UNIT_DEFINES_SVH
`define MIDI_INPUT_EVENT_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MIPU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("midi parser assertion failed");

// next-cycle implication, checked outside reset
`define MIPU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("midi parser assertion failed");

`endif

// ===== rtl/mipu_pkg.sv =====
// shared types and constants of the midi input event parser unit
// no dependencies; used by every module of the unit
package mipu_pkg;

  // payload of one received item
  typedef struct packed {
    logic       mode;       // 0 midi byte, 1 timer tick
    logic [7:0] midi_byte;
  } in_item_t;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF      = 3'd0,
    KIND_NOTE_ON       = 3'd1,
    KIND_ALL_OFF       = 3'd2,
    KIND_PROGRAM       = 3'd3,
    KIND_RESET         = 3'd4,
    KIND_SENSE_TIMEOUT = 3'd5
  } event_kind_t;

  // payload of one result event
  typedef struct packed {
    event_kind_t event_kind;
    logic [3:0]  channel;
    logic [6:0]  value;
  } out_item_t;

  // classified item kinds passed from front to back
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_STATUS = 2'd1,
    OP_DATA   = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [1:0] exp_cnt;  // data bytes expected after a status byte
    logic [7:0] data;
  } cmd_t;

  // queue status seen by the neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  localparam logic [1:0] IGNORE_DATA   = 2'd3;
  localparam logic [7:0] STATUS_SENSE  = 8'hFE;
  localparam logic [7:0] STATUS_RESET  = 8'hFF;
  localparam logic [6:0] CTRL_ALL_OFF  = 7'h7B;
  localparam logic [15:0] SENSE_TIMEOUT_RESET = 16'd300;

  localparam int CMD_AW    = 2;
  localparam int CMD_DEPTH = 1 << CMD_AW;
  localparam int EVT_AW    = 2;
  localparam int EVT_DEPTH = 1 << EVT_AW;

endpackage

// ===== rtl/mipu_front.sv =====
// front end: classifies received bytes and ticks into parser commands
// depends on mipu_pkg
module mipu_front (
  input  logic                 in_push,
  input  mipu_pkg::in_item_t   in_item,
  output logic                 in_full,
  input  mipu_pkg::fifo_stat_t cmd_stat,
  output logic                 cmd_push,
  output mipu_pkg::cmd_t       cmd
);

  function automatic logic [1:0] expected_for(input logic [7:0] s);
    logic [1:0] n;
    n = 2'd0;
    if (s[7:6] == 2'b10 || s[7:4] == 4'hE || s == 8'hF2) begin
      n = 2'd2;
    end else if (s == 8'hF0) begin
      n = mipu_pkg::IGNORE_DATA;
    end else if (s[7:5] == 3'b110 || s == 8'hF1 || s == 8'hF3) begin
      n = 2'd1;
    end
    return n;
  endfunction

  assign in_full  = cmd_stat.full;
  assign cmd_push = in_push && !cmd_stat.full;

  always_comb begin
    cmd.data    = in_item.midi_byte;
    cmd.exp_cnt = expected_for(in_item.midi_byte);
    if (in_item.mode) begin
      cmd.op = mipu_pkg::OP_TICK;
    end else if (in_item.midi_byte[7]) begin
      cmd.op = mipu_pkg::OP_STATUS;
    end else begin
      cmd.op = mipu_pkg::OP_DATA;
    end
  end

endmodule

// ===== rtl/mipu_cmd_fifo.sv =====
// small command queue between the front and the back of the parser
// depends on mipu_pkg
module mipu_cmd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mipu_pkg::cmd_t       wdata,
  input  logic                 pop,
  output mipu_pkg::cmd_t       rdata,
  output mipu_pkg::fifo_stat_t stat
);

  mipu_pkg::cmd_t                 mem_r [mipu_pkg::CMD_DEPTH];
  logic [mipu_pkg::CMD_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [mipu_pkg::CMD_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [mipu_pkg::CMD_AW:0]      count_r, count_nxt;
  logic                           push_ok, pop_ok;

  assign stat.full  = (count_r == (mipu_pkg::CMD_AW+1)'(mipu_pkg::CMD_DEPTH));
  assign stat.empty = (count_r == '0);
  assign push_ok    = push && !stat.full;
  assign pop_ok     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/mipu_back.sv =====
// back end: running status parser and active sensing watchdog
// depends on mipu_pkg; consumes commands, produces events
module mipu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mipu_pkg::cmd_t       cmd,
  input  mipu_pkg::fifo_stat_t cmd_stat,
  output logic                 cmd_pop,
  input  mipu_pkg::fifo_stat_t evt_stat,
  output logic                 evt_push,
  output mipu_pkg::out_item_t  evt,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data
);

  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_CONTROL  = 4'hB;
  localparam logic [3:0] NIB_PROGRAM  = 4'hC;
  localparam logic [3:0] NIB_SYSTEM   = 4'hF;

  logic [15:0] sense_timeout_r;
  logic [7:0]  running_status_r, running_status_nxt;
  logic [6:0]  first_data_r, first_data_nxt;
  logic [1:0]  data_count_r, data_count_nxt;
  logic [1:0]  expected_count_r, expected_count_nxt;
  logic        sensing_armed_r, sensing_armed_nxt;
  logic [15:0] sense_timer_r, sense_timer_nxt;
  logic        go, emit;
  logic [15:0] timer_inc;
  logic [1:0]  count_inc;
  logic [6:0]  first_eff;

  assign go       = !cmd_stat.empty && !evt_stat.full;
  assign cmd_pop  = go;
  assign evt_push = go && emit;

  always_comb begin
    running_status_nxt = running_status_r;
    first_data_nxt     = first_data_r;
    data_count_nxt     = data_count_r;
    expected_count_nxt = expected_count_r;
    sensing_armed_nxt  = sensing_armed_r;
    sense_timer_nxt    = sense_timer_r;
    emit               = 1'b0;
    evt.event_kind     = mipu_pkg::KIND_NOTE_OFF;
    evt.channel        = 4'd0;
    evt.value          = 7'd0;
    timer_inc = (sense_timer_r == 16'hFFFF) ? sense_timer_r : sense_timer_r + 16'd1;
    count_inc = (data_count_r < 2'd2) ? data_count_r + 2'd1 : data_count_r;
    first_eff = (data_count_r == 2'd0) ? cmd.data[6:0] : first_data_r;

    if (go) begin
      case (cmd.op)
        mipu_pkg::OP_TICK: begin
          if (sensing_armed_r) begin
            sense_timer_nxt = timer_inc;
            if (timer_inc >= sense_timeout_r) begin
              sensing_armed_nxt = 1'b0;
              emit              = 1'b1;
              evt.event_kind    = mipu_pkg::KIND_SENSE_TIMEOUT;
            end
          end
        end
        mipu_pkg::OP_STATUS: begin
          running_status_nxt = cmd.data;
          data_count_nxt     = 2'd0;
          expected_count_nxt = cmd.exp_cnt;
          if (cmd.data == mipu_pkg::STATUS_SENSE) begin
            sensing_armed_nxt = 1'b1;
            sense_timer_nxt   = 16'd0;
          end else if (cmd.data == mipu_pkg::STATUS_RESET) begin
            emit           = 1'b1;
            evt.event_kind = mipu_pkg::KIND_RESET;
          end
        end
        mipu_pkg::OP_DATA: begin
          first_data_nxt = first_eff;
          data_count_nxt = count_inc;
          if (expected_count_r != mipu_pkg::IGNORE_DATA && count_inc >= expected_count_r) begin
            data_count_nxt = 2'd0;
            evt.channel    = running_status_r[3:0];
            // only channel voice messages produce events
            if (running_status_r[7] && running_status_r[7:4] != NIB_SYSTEM) begin
              case (running_status_r[7:4])
                NIB_NOTE_OFF: begin
                  emit           = 1'b1;
                  evt.event_kind = mipu_pkg::KIND_NOTE_OFF;
                  evt.value      = first_eff;
                end
                NIB_NOTE_ON: begin
                  emit           = 1'b1;
                  evt.event_kind = (cmd.data[6:0] == 7'd0) ? mipu_pkg::KIND_NOTE_OFF
                                                           : mipu_pkg::KIND_NOTE_ON;
                  evt.value      = first_eff;
                end
                NIB_CONTROL: begin
                  if (first_eff == mipu_pkg::CTRL_ALL_OFF) begin
                    emit           = 1'b1;
                    evt.event_kind = mipu_pkg::KIND_ALL_OFF;
                  end
                end
                NIB_PROGRAM: begin
                  emit           = 1'b1;
                  evt.event_kind = mipu_pkg::KIND_PROGRAM;
                  evt.value      = first_eff;
                end
                default: begin
                  emit = 1'b0;
                end
              endcase
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sense_timeout_r  <= mipu_pkg::SENSE_TIMEOUT_RESET;
      running_status_r <= 8'd0;
      first_data_r     <= 7'd0;
      data_count_r     <= 2'd0;
      expected_count_r <= mipu_pkg::IGNORE_DATA;
      sensing_armed_r  <= 1'b0;
      sense_timer_r    <= 16'd0;
    end else begin
      if (cfg_we) begin
        sense_timeout_r <= cfg_data;
      end
      running_status_r <= running_status_nxt;
      first_data_r     <= first_data_nxt;
      data_count_r     <= data_count_nxt;
      expected_count_r <= expected_count_nxt;
      sensing_armed_r  <= sensing_armed_nxt;
      sense_timer_r    <= sense_timer_nxt;
    end
  end

endmodule

// ===== rtl/mipu_evt_fifo.sv =====
// result queue holding events until the consumer pops them
// depends on mipu_pkg
module mipu_evt_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mipu_pkg::out_item_t  wdata,
  input  logic                 pop,
  output mipu_pkg::out_item_t  rdata,
  output mipu_pkg::fifo_stat_t stat
);

  mipu_pkg::out_item_t            mem_r [mipu_pkg::EVT_DEPTH];
  logic [mipu_pkg::EVT_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [mipu_pkg::EVT_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [mipu_pkg::EVT_AW:0]      count_r, count_nxt;
  logic                           push_ok, pop_ok;

  assign stat.full  = (count_r == (mipu_pkg::EVT_AW+1)'(mipu_pkg::EVT_DEPTH));
  assign stat.empty = (count_r == '0);
  assign push_ok    = push && !stat.full;
  assign pop_ok     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/midi_input_event_parser_unit.sv =====
// top level of the midi input event parser unit
// depends on mipu_pkg, mipu_front, mipu_cmd_fifo, mipu_back, mipu_evt_fifo
// and the assertion macros in midi_input_event_parser_unit_defines.svh
//
//  channel   direction  handshake           payload
//  in_*      in         in_push / in_full   in_item  (mode, midi_byte)
//  out_*     out        out_pop / out_empty out_item (event_kind, channel, value)
//  cfg_*     in         cfg_valid/cfg_ready cfg_data (sense_timeout_ticks)
//
// one item per clock sustained while the command queue has room; an item taken
// is written into the command queue, the back end parses it at the head of that
// queue when the event queue has room and writes its event into the event queue,
// from which it can be popped
// the back end handles one command per cycle while the event queue has room, with combinational parser logic
// synchronous active-low reset empties both queues, clears the parser state
// and loads a sense timeout of 300 ticks
// out_pop held low fills the 4-entry event queue, then the 4-entry command
// queue, and in_full rises; cfg_ready is high while the command queue is empty

`include "midi_input_event_parser_unit_defines.svh"

module midi_input_event_parser_unit (
  input  logic                clk,
  input  logic                rst_n,
  // input queue side
  input  logic                in_push,
  input  mipu_pkg::in_item_t  in_item,
  output logic                in_full,
  // result queue side
  output logic                out_empty,
  input  logic                out_pop,
  output mipu_pkg::out_item_t out_item,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  mipu_pkg::cmd_t       front_cmd;
  mipu_pkg::cmd_t       head_cmd;
  mipu_pkg::fifo_stat_t cmd_stat;
  mipu_pkg::fifo_stat_t evt_stat;
  mipu_pkg::out_item_t  back_evt;
  logic                 cmd_push;
  logic                 cmd_pop;
  logic                 evt_push;
  logic                 cfg_we;

  // register writes wait until every queued command has been parsed
  assign cfg_ready = cmd_stat.empty;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign out_empty = evt_stat.empty;

  // classify bytes and ticks
  mipu_front u_front (
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .cmd_stat (cmd_stat),
    .cmd_push (cmd_push),
    .cmd      (front_cmd)
  );

  // decouples the front from back-end stalls
  mipu_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (front_cmd),
    .pop   (cmd_pop),
    .rdata (head_cmd),
    .stat  (cmd_stat)
  );

  // running status parser and watchdog
  mipu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (head_cmd),
    .cmd_stat (cmd_stat),
    .cmd_pop  (cmd_pop),
    .evt_stat (evt_stat),
    .evt_push (evt_push),
    .evt      (back_evt),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // events wait here for the consumer
  mipu_evt_fifo u_evt_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (evt_push),
    .wdata (back_evt),
    .pop   (out_pop),
    .rdata (out_item),
    .stat  (evt_stat)
  );

  // the back end never produces an event the result queue cannot hold
  `MIPU_ASSERT_NOW(a_evt_no_overflow, evt_push, !evt_stat.full)
  // a command is consumed only when it exists and there is room for its event
  `MIPU_ASSERT_NOW(a_pop_has_room, cmd_pop, !cmd_stat.empty && !evt_stat.full)
  // an accepted item is held in the command queue on the next cycle
  `MIPU_ASSERT_NEXT(a_accept_queued, in_push && !in_full, !cmd_stat.empty)

endmodule

// ===== sim/tb_midi_input_event_parser_unit.sv =====
// self-checking testbench for the midi input event parser unit
// depends on mipu_pkg and midi_input_event_parser_unit; a scoreboard class
// predicts each event from the accepted requests and checks the result queue

module tb_midi_input_event_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // status nibbles of the channel messages
  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_POLY_AT  = 4'hA;
  localparam logic [3:0] NIB_CTRL     = 4'hB;
  localparam logic [3:0] NIB_PROGRAM  = 4'hC;
  localparam logic [3:0] NIB_CHAN_AT  = 4'hD;
  localparam logic [3:0] NIB_PITCH    = 4'hE;
  localparam logic [3:0] NIB_SYSTEM   = 4'hF;

  // system statuses; all but the clock take data
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_TIME_CODE = 8'hF1;
  localparam logic [7:0] ST_SONG_POS  = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
  localparam logic [7:0] ST_CLOCK     = 8'hF8;

  localparam logic       MODE_BYTE = 1'b0;
  localparam logic       MODE_TICK = 1'b1;

  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_TIMEOUT   = 65535;
  localparam int LONG_TICKS     = 100;

  // scoreboard: its own copy of the parser state and the expected events
  class event_scoreboard;
    logic [15:0]         timeout_ticks;
    logic [7:0]          run_status;
    logic [6:0]          first_byte;
    logic [1:0]          byte_count;
    logic [1:0]          bytes_needed;
    logic                armed;
    logic [15:0]         sense_ticks;
    mipu_pkg::out_item_t due_events[$];
    int                  errors;

    function void clear();
      timeout_ticks = mipu_pkg::SENSE_TIMEOUT_RESET;
      run_status    = 8'h00;
      first_byte    = 7'h00;
      byte_count    = 2'd0;
      bytes_needed  = mipu_pkg::IGNORE_DATA;
      armed         = 1'b0;
      sense_ticks   = 16'h0000;
      due_events.delete();
      errors        = 0;
    endfunction

    function void set_timeout(logic [15:0] ticks);
      timeout_ticks = ticks;
    endfunction

    function int pending();
      return due_events.size();
    endfunction

    function void add_event(mipu_pkg::event_kind_t kind, logic [3:0] chan,
                            logic [6:0] val);
      mipu_pkg::out_item_t ev;
      ev.event_kind = kind;
      ev.channel    = chan;
      ev.value      = val;
      due_events.push_back(ev);
    endfunction

    // data bytes that a status byte asks for
    function logic [1:0] data_bytes_for(logic [7:0] st);
      case (st[7:4])
        NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_PITCH: return 2'd2;
        NIB_PROGRAM, NIB_CHAN_AT: return 2'd1;
        NIB_SYSTEM: begin
          if (st == ST_SONG_POS) return 2'd2;
          if (st == ST_SYSEX) return mipu_pkg::IGNORE_DATA;
          if (st == ST_TIME_CODE || st == ST_SONG_SEL) return 2'd1;
          return 2'd0;
        end
        default: return 2'd0;
      endcase
    endfunction

    function void note_request(mipu_pkg::in_item_t req);
      logic [7:0] b;
      logic [3:0] chan;
      b    = req.midi_byte;
      chan = run_status[3:0];
      if (req.mode == MODE_TICK) begin
        if (!armed) return;
        if (sense_ticks != 16'hFFFF) sense_ticks++;
        if (sense_ticks >= timeout_ticks) begin
          armed = 1'b0;
          add_event(mipu_pkg::KIND_SENSE_TIMEOUT, 4'd0, 7'd0);
        end
        return;
      end
      if (b[7]) begin
        run_status   = b;
        byte_count   = 2'd0;
        bytes_needed = data_bytes_for(b);
        if (b == mipu_pkg::STATUS_SENSE) begin
          armed       = 1'b1;
          sense_ticks = 16'h0000;
        end else if (b == mipu_pkg::STATUS_RESET) begin
          add_event(mipu_pkg::KIND_RESET, 4'd0, 7'd0);
        end
        return;
      end
      if (byte_count < 2'd2) begin
        if (byte_count == 2'd0) first_byte = b[6:0];
        byte_count++;
      end
      if (bytes_needed == mipu_pkg::IGNORE_DATA || byte_count < bytes_needed) return;
      byte_count = 2'd0;
      case (run_status[7:4])
        NIB_NOTE_OFF: add_event(mipu_pkg::KIND_NOTE_OFF, chan, first_byte);
        NIB_NOTE_ON: begin
          if (b == 8'd0) add_event(mipu_pkg::KIND_NOTE_OFF, chan, first_byte);
          else add_event(mipu_pkg::KIND_NOTE_ON, chan, first_byte);
        end
        NIB_CTRL: begin
          if (first_byte == mipu_pkg::CTRL_ALL_OFF) begin
            add_event(mipu_pkg::KIND_ALL_OFF, chan, 7'd0);
          end
        end
        NIB_PROGRAM: add_event(mipu_pkg::KIND_PROGRAM, chan, first_byte);
        default: ;
      endcase
    endfunction

    function void check_event(mipu_pkg::out_item_t got);
      mipu_pkg::out_item_t want;
      if (due_events.size() == 0) begin
        $display("%0t: unexpected event, expected none actual kind %0d channel %0d value %0d",
                 $time, got.event_kind, got.channel, got.value);
        errors++;
        return;
      end
      want = due_events.pop_front();
      if (got.event_kind !== want.event_kind) begin
        $display("%0t: event_kind mismatch, expected %0d actual %0d",
                 $time, want.event_kind, got.event_kind);
        errors++;
      end
      if (got.channel !== want.channel) begin
        $display("%0t: channel mismatch, expected %0d actual %0d",
                 $time, want.channel, got.channel);
        errors++;
      end
      if (got.value !== want.value) begin
        $display("%0t: value mismatch, expected %0d actual %0d",
                 $time, want.value, got.value);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  mipu_pkg::in_item_t  in_item = '0;
  logic                in_full;
  logic                out_empty;
  logic                out_pop = 1'b0;
  mipu_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [15:0]         cfg_data = 16'h0000;

  event_scoreboard sb;
  logic [7:0]  last_status = 8'h00;  // last status byte sent, for running status reuse
  logic [15:0] phase_timeout = mipu_pkg::SENSE_TIMEOUT_RESET;
  logic        no_idle = 1'b0;       // both sides run flat out while set
  int          sent = 0;
  int          pop_hold = 0;
  int          idle_cycles = 0;

  midi_input_event_parser_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // gap length for either side: mostly none, sometimes short, now and then long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // result side: pop with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_hold > 0 && !no_idle) begin
      out_pop <= 1'b0;
      pop_hold--;
    end else begin
      out_pop <= 1'b1;
      pop_hold = idle_gap();
    end
  end

  // monitor: every handshake seen at the edge feeds the scoreboard
  // results are checked before the same edge's request, which cannot
  // affect them anyway given the queue latency
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) sb.check_event(out_item);
      if (in_push && !in_full) sb.note_request(in_item);
      if (cfg_valid && cfg_ready) sb.set_timeout(cfg_data);
      if ((out_pop && !out_empty) || (in_push && !in_full) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
          $display("FAIL midi_input_event_parser_unit");
          $finish;
        end
      end
    end
  end

  // one request on the input side, after an optional gap
  task automatic send_item(logic m, logic [7:0] b);
    int gap;
    mipu_pkg::in_item_t req;
    gap = idle_gap();
    req.mode      = m;
    req.midi_byte = b;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= req;
    if (m == MODE_BYTE && b[7]) last_status = b;
    do @(posedge clk); while (in_full);
    sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(MODE_BYTE, b);
  endtask

  // the byte field of a tick carries random junk
  task automatic send_tick();
    send_item(MODE_TICK, 8'($urandom_range(0, 255)));
  endtask

  // stop sending until every expected event is out and the pipe is quiet
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(logic [15:0] ticks);
    settle();
    phase_timeout = ticks;
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one random message: mostly well formed, some broken, some noise
  task automatic play_message();
    int r;
    int n;
    int burst;
    logic [3:0] nib;
    logic [7:0] st;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      // channel message, sometimes under running status
      if (last_status[7] && last_status[7:4] != NIB_SYSTEM && $urandom_range(0, 2) == 0) begin
        st = last_status;
      end else begin
        case ($urandom_range(0, 9))
          0, 1:    nib = NIB_NOTE_OFF;
          2, 3, 4: nib = NIB_NOTE_ON;
          5:       nib = NIB_POLY_AT;
          6, 7:    nib = NIB_CTRL;
          8:       nib = NIB_PROGRAM;
          default: nib = $urandom_range(0, 1) ? NIB_CHAN_AT : NIB_PITCH;
        endcase
        st = {nib, 4'($urandom_range(0, 15))};
        send_byte(st);
      end
      n = (st[7:4] == NIB_PROGRAM || st[7:4] == NIB_CHAN_AT) ? 1 : 2;
      if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 3);  // truncated or overlong
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(0, 127));
        if (i == 0 && st[7:4] == NIB_CTRL && $urandom_range(0, 1)) begin
          b = {1'b0, mipu_pkg::CTRL_ALL_OFF};
        end
        if (i == 1 && $urandom_range(0, 3) == 0) b = 8'h00;
        send_byte(b);
      end
    end else if (r < 63) begin
      // system common, sysex start included, with a few data bytes
      send_byte(ST_SYSEX | 8'($urandom_range(0, 7)));
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 127)));
    end else if (r < 70) begin
      // real-time byte, sense and reset among them
      send_byte(ST_CLOCK | 8'($urandom_range(0, 7)));
    end else if (r < 80) begin
      // sense then a burst of ticks around the timeout
      send_byte(mipu_pkg::STATUS_SENSE);
      burst = (phase_timeout > 37) ? 40 : int'(phase_timeout) + 3;
      n = $urandom_range(0, burst);
      for (int i = 0; i < n; i++) send_tick();
    end else if (r < 90) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) send_tick();
    end else begin
      if ($urandom_range(0, 1)) send_tick();
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_traffic(int n_items);
    int first;
    first = sent;
    while (sent - first < n_items) begin
      play_message();
      // now and then the sender waits for every result to drain
      if ($urandom_range(0, 49) == 0) settle();
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset timeout
    send_byte(8'h00);                                       // data before any status
    send_byte(8'h90); send_byte(8'h3C); send_byte(8'h7F);   // note on
    send_byte(8'h7F); send_byte(8'h00);                     // running status, zero velocity
    send_byte(8'h8F); send_byte(8'h40); send_byte(8'h01);   // note off, channel 15
    send_byte(8'hB3); send_byte(8'h7B); send_byte(8'h00);   // all notes off
    send_byte(8'hB3); send_byte(8'h07); send_byte(8'h7F);   // other controller, no event
    send_byte(8'hC5); send_byte(8'h7F);                     // program change
    send_byte(ST_SYSEX); send_byte(8'h12);                  // sysex data is dropped
    send_byte(ST_SONG_POS); send_byte(8'h01); send_byte(8'h02);  // system data, no event
    send_byte(mipu_pkg::STATUS_RESET);
    send_tick();                                            // tick while not armed
    send_byte(mipu_pkg::STATUS_SENSE);
    send_tick();

    // timeout register zero fires on the first tick after arming
    write_timeout(16'd0);
    send_byte(mipu_pkg::STATUS_SENSE);
    send_tick();
    send_tick();
    run_traffic(350);

    write_timeout(16'd1);
    run_traffic(350);

    // a stretch with no idling on either side
    write_timeout(16'($urandom_range(2, 30)));
    no_idle = 1'b1;
    run_traffic(350);
    no_idle = 1'b0;

    write_timeout(16'($urandom_range(2, 30)));
    run_traffic(350);

    write_timeout(mipu_pkg::SENSE_TIMEOUT_RESET);
    run_traffic(400);

    // largest timeout: arm once, a run of ticks stays far below it
    write_timeout(16'(LONG_TIMEOUT));
    send_byte(mipu_pkg::STATUS_SENSE);
    repeat (LONG_TICKS) send_tick();

    settle();
    if (sb.errors == 0) begin
      $display("PASS midi_input_event_parser_unit");
    end else begin
      $display("FAIL midi_input_event_parser_unit");
    end
    $finish;
  end

endmodule
